// File: rtl/strmq_pkg.sv
// ----------------------------------------------------------------------------
// strmq_pkg
// Shared widths and defaults of the sparse table range minimum unit.
// ----------------------------------------------------------------------------
package strmq_pkg;

  localparam int unsigned INDEX_W          = 10;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned LEVELS_DEF       = 11;

  // request layout
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned S_VALUE_LO = 0;
  localparam int unsigned S_LEFT_LO  = VALUE_W;
  localparam int unsigned S_RIGHT_LO = VALUE_W + INDEX_W;
  localparam int unsigned S_USED_W   = VALUE_W + 2 * INDEX_W;

  // result layout
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 1;
  localparam int unsigned M_USED_W  = INDEX_W + VALUE_W;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

endpackage

// File: rtl/strmq_ram.sv
// ----------------------------------------------------------------------------
// strmq_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module strmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sparse_table_range_min_unit.sv
// ----------------------------------------------------------------------------
// sparse_table_range_min_unit
// Range minimum engine on a sparse table held in two RAMs: an element RAM
// and a level RAM of minimum positions addressed by {level, start}.
//
//   channel  dir  tuser (low first)        tdata (low first)
//   s_axis   in   action, restart          value, left_index, right_index
//   m_axis   out  range_error              min_index, min_value
//
// An append writes the element and its level zero entry, then updates each
// higher level that the new element closes; an append to a full table without
// restart is ignored. The level updates run as a three stage pipeline (level
// RAM read, element RAM read, compare and write back), one level per cycle. A
// query makes two level RAM reads and two element RAM reads on single read
// ports; a bad range skips them.
// Reset returns the unit to idle and clears the element count, the append
// pipeline valids and the output valid; RAM contents stay undefined. A request
// is taken in idle; a finished result waits in the output register, holding the
// unit only when a second result is ready behind it.
module sparse_table_range_min_unit #(
  parameter int unsigned MAX_ELEMENTS = strmq_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned LEVELS       = strmq_pkg::LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // value, left_index, right_index, zero pad
  input  logic [strmq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action, restart
  input  logic [strmq_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // min_index, min_value, zero pad
  output logic [strmq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // range_error
  output logic [strmq_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  localparam int unsigned IdxW  = strmq_pkg::INDEX_W;
  localparam int unsigned ValW  = strmq_pkg::VALUE_W;
  localparam int unsigned PosW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LvlW  = $clog2(LEVELS);
  localparam int unsigned LcW   = $clog2(LEVELS + 1);
  localparam int unsigned SpanA = (CntW > IdxW + 1) ? CntW : IdxW + 1;
  localparam int unsigned SpanW = (SpanA > LEVELS + 1) ? SpanA : LEVELS + 1;
  localparam int unsigned TblDepth = LEVELS * (1 << PosW);
  localparam int unsigned TblAw    = LvlW + PosW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_AINIT = 8'b0000_0010,
    S_ARUN  = 8'b0000_0100,
    S_Q0    = 8'b0000_1000,
    S_Q1    = 8'b0001_0000,
    S_Q2    = 8'b0010_0000,
    S_Q3    = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;

  // request fields
  logic            restart_q;
  logic [ValW-1:0] value_q;
  logic [IdxW-1:0] left_q, right_q;

  // append pipeline
  logic [PosW-1:0] p_q;
  logic [LcW-1:0]  lvl_q, lvl_d;
  logic            v1_q, v1_d, v2_q, v2_d;
  logic [PosW-1:0] s1_q, s2_q, a2_q;
  logic [LvlW-1:0] l1_q, l2_q;
  logic [PosW-1:0] best_idx_q;
  logic [ValW-1:0] best_val_q;

  // query
  logic            err_q;
  logic [PosW-1:0] a_q, b_q;
  logic [ValW-1:0] va_q, vb_q;

  // output register
  logic                 m_tvalid_q, m_tvalid_d;
  logic [IdxW-1:0]      m_idx_q;
  logic [ValW-1:0]      m_val_q;
  logic                 m_err_q;

  // RAM ports
  logic              tbl_we;
  logic [TblAw-1:0]  tbl_waddr, tbl_raddr;
  logic [PosW-1:0]   tbl_wdata, tbl_rdata;
  logic              elem_we;
  logic [PosW-1:0]   elem_waddr;
  logic [ValW-1:0]   elem_rdata;

  // control strobes
  logic s_accept, full, init_go, st2_win, out_load;

  // derived values
  logic [PosW-1:0]  p_new;
  logic [SpanW-1:0] pow_w, p1_w, s_w;
  logic             issue_ok;
  logic [LcW-1:0]   lvl_m1;
  logic [SpanW-1:0] left_w, right_w, cnt_w, len_w, rb_w;
  logic             q_err;
  logic [LvlW-1:0]  qk;
  logic             res_win;
  logic [PosW-1:0]  res_idx;
  logic [SpanW-1:0] res_idx_w;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // append helpers
  assign full    = (count_q == CntW'(MAX_ELEMENTS)) && !restart_q;
  assign p_new   = restart_q ? '0 : count_q[PosW-1:0];
  assign init_go = (state_q == S_AINIT) && !full;
  assign pow_w   = SpanW'(1) << lvl_q;
  assign p1_w    = SpanW'(p_q) + SpanW'(1);
  assign s_w     = p1_w - pow_w;
  assign issue_ok = (state_q == S_ARUN) && (lvl_q < LcW'(LEVELS)) && (pow_w <= p1_w);
  assign lvl_m1  = lvl_q - LcW'(1);
  assign st2_win = $signed(elem_rdata) <= $signed(best_val_q);

  // query helpers
  assign left_w  = SpanW'(left_q);
  assign right_w = SpanW'(right_q);
  assign cnt_w   = SpanW'(count_q);
  assign q_err   = (left_w > right_w) || (right_w >= cnt_w);
  assign len_w   = right_w - left_w + SpanW'(1);

  always_comb begin
    int unsigned kr;
    kr = 0;
    for (int unsigned i = 0; i < SpanW; i++) begin
      if (len_w[i]) begin
        kr = i;
      end
    end
    if (kr > LEVELS - 1) begin
      kr = LEVELS - 1;
    end
    qk = LvlW'(kr);
  end

  assign rb_w = right_w + SpanW'(1) - (SpanW'(1) << qk);

  // result selection
  assign res_win   = $signed(va_q) <= $signed(vb_q);
  assign res_idx   = res_win ? a_q : b_q;
  assign res_idx_w = SpanW'(res_idx);
  assign out_load  = (state_q == S_RES) && (!m_tvalid_q || m_axis_tready);

  // RAM port selection
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = {LvlW'(0), p_new};
    tbl_wdata  = p_new;
    tbl_raddr  = {lvl_m1[LvlW-1:0], s_w[PosW-1:0]};
    elem_we    = init_go;
    elem_waddr = p_new;
    if (init_go) begin
      tbl_we = 1'b1;
    end else if (v2_q) begin
      tbl_we    = 1'b1;
      tbl_waddr = {l2_q, s2_q};
      tbl_wdata = st2_win ? a2_q : best_idx_q;
    end
    if (state_q == S_Q0) begin
      tbl_raddr = {qk, left_w[PosW-1:0]};
    end else if (state_q == S_Q1) begin
      tbl_raddr = {qk, rb_w[PosW-1:0]};
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lvl_d      = lvl_q;
    v1_d       = issue_ok;
    v2_d       = v1_q;
    m_tvalid_d = m_tvalid_q;
    if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = (s_axis_tuser[0] == strmq_pkg::ACT_QUERY) ? S_Q0 : S_AINIT;
        end
      end
      S_AINIT: begin
        if (full) begin
          state_d = S_IDLE;
        end else begin
          count_d = CntW'(p_new) + CntW'(1);
          lvl_d   = LcW'(1);
          state_d = S_ARUN;
        end
      end
      S_ARUN: begin
        if (issue_ok) begin
          lvl_d = lvl_q + LcW'(1);
        end else if (!v1_q && !v2_q) begin
          state_d = S_IDLE;
        end
      end
      S_Q0:    state_d = q_err ? S_RES : S_Q1;
      S_Q1:    state_d = S_Q2;
      S_Q2:    state_d = S_Q3;
      S_Q3:    state_d = S_RES;
      S_RES: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      lvl_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      lvl_q      <= lvl_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      restart_q <= s_axis_tuser[1];
      value_q   <= s_axis_tdata[strmq_pkg::S_VALUE_LO +: ValW];
      left_q    <= s_axis_tdata[strmq_pkg::S_LEFT_LO +: IdxW];
      right_q   <= s_axis_tdata[strmq_pkg::S_RIGHT_LO +: IdxW];
    end
    if (init_go) begin
      p_q        <= p_new;
      best_idx_q <= p_new;
      best_val_q <= value_q;
    end else if (v2_q && st2_win) begin
      best_idx_q <= a2_q;
      best_val_q <= elem_rdata;
    end
    s1_q <= s_w[PosW-1:0];
    l1_q <= lvl_q[LvlW-1:0];
    s2_q <= s1_q;
    l2_q <= l1_q;
    a2_q <= tbl_rdata;
    if (state_q == S_Q0) begin
      err_q <= q_err;
    end
    if (state_q == S_Q1) begin
      a_q <= tbl_rdata;
    end
    if (state_q == S_Q2) begin
      b_q  <= tbl_rdata;
      va_q <= elem_rdata;
    end
    if (state_q == S_Q3) begin
      vb_q <= elem_rdata;
    end
    if (out_load) begin
      if (err_q) begin
        m_idx_q <= '0;
        m_val_q <= '0;
        m_err_q <= 1'b1;
      end else begin
        m_idx_q <= res_idx_w[IdxW-1:0];
        m_val_q <= res_win ? va_q : vb_q;
        m_err_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {{(strmq_pkg::M_TDATA_W - strmq_pkg::M_USED_W){1'b0}},
                          m_val_q, m_idx_q};
  assign m_axis_tuser  = m_err_q;

  // minimum positions per level
  strmq_ram #(
    .WIDTH (PosW),
    .DEPTH (TblDepth)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // element values, always read at the position just returned by the level ram
  strmq_ram #(
    .WIDTH (ValW),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (value_q),
    .raddr_i (tbl_rdata),
    .rdata_o (elem_rdata)
  );

endmodule
